// ===== sv/dlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor table package
// Sizes, derived widths, opcodes and shared types of the two-level
// descriptor table.
// ----------------------------------------------------------------------------
package dlt_pkg;

  // Table sizes.
  localparam int unsigned USER_COUNT     = 8;
  localparam int unsigned SLOTS_PER_USER = 16;
  localparam int unsigned SYSTEM_ENTRIES = 64;

  // Derived widths.
  localparam int unsigned SLOT_TOTAL = USER_COUNT * SLOTS_PER_USER;
  localparam int unsigned SLOT_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int unsigned DESC_W     = (SLOTS_PER_USER > 1) ? $clog2(SLOTS_PER_USER) : 1;
  localparam int unsigned ENTRY_W    = (SYSTEM_ENTRIES > 1) ? $clog2(SYSTEM_ENTRIES) : 1;

  // The free-bit scanner looks at one chunk of eight lanes per cycle.
  localparam int unsigned SCAN_LANES   = 8;
  localparam int unsigned LANE_W       = 3;
  localparam int unsigned SLOT_CHUNKS  = (SLOTS_PER_USER + SCAN_LANES - 1) / SCAN_LANES;
  localparam int unsigned ENTRY_CHUNKS = (SYSTEM_ENTRIES + SCAN_LANES - 1) / SCAN_LANES;
  localparam int unsigned MAX_CHUNKS   =
    (SLOT_CHUNKS > ENTRY_CHUNKS) ? SLOT_CHUNKS : ENTRY_CHUNKS;
  localparam int unsigned CHUNK_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned SCAN_W       = CHUNK_W + LANE_W;

  // Entry metadata word: flags over inode.
  localparam int unsigned META_W = 24;

  // Inode reported by a lookup through an invalid descriptor.
  localparam logic [15:0] INODE_NONE = 16'hFFFF;

  // Opcodes.
  typedef enum logic [2:0] {
    OP_OPEN       = 3'd0,
    OP_CLOSE      = 3'd1,
    OP_LOOKUP     = 3'd2,
    OP_SET_OFFSET = 3'd3,
    OP_CLOSE_ALL  = 3'd4
  } op_e;

  // Result of one scanner pass over a chunk.
  typedef struct packed {
    logic              found;
    logic [LANE_W-1:0] lane;
  } scan_res_t;

  // One result item.
  typedef struct packed {
    logic        status;
    logic [7:0]  fd_out;
    logic [15:0] inode_out;
    logic [31:0] offset_out;
    logic [7:0]  flags_out;
    logic        is_open;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/dlt_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one descriptor table command.
// ----------------------------------------------------------------------------
interface dlt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  user;
  logic [7:0]  descriptor;
  logic [15:0] inode_in;
  logic [7:0]  mode_flags;
  logic [31:0] new_offset;

  modport source (
    output valid, opcode, user, descriptor, inode_in, mode_flags, new_offset,
    input  ready
  );

  modport sink (
    input  valid, opcode, user, descriptor, inode_in, mode_flags, new_offset,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/dlt_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one descriptor table result.
// ----------------------------------------------------------------------------
interface dlt_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  fd_out;
  logic [15:0] inode_out;
  logic [31:0] offset_out;
  logic [7:0]  flags_out;
  logic        is_open;

  modport source (
    output valid, status, fd_out, inode_out, offset_out, flags_out, is_open,
    input  ready
  );

  modport sink (
    input  valid, status, fd_out, inode_out, offset_out, flags_out, is_open,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/dlt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlt_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/dlt_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free-lane scanner
// Finds the lowest set bit of one chunk of free flags; shared by the slot
// search and the system entry search.
// ----------------------------------------------------------------------------
module dlt_scan import dlt_pkg::*; (
  input  logic [SCAN_LANES-1:0] free_i,
  output scan_res_t             res_o
);

  // Priority encoder, lowest lane wins.
  always_comb begin
    res_o.found = |free_i;
    res_o.lane  = '0;
    for (int k = SCAN_LANES - 1; k >= 0; k--) begin
      if (free_i[k]) begin
        res_o.lane = LANE_W'(k);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/two_level_descriptor_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-level descriptor table
// Per-user descriptor slots that link into a shared table of open-file
// entries; a small sequencer drives one shared free-lane scanner.
// ----------------------------------------------------------------------------
//  Channel  Dir  Modport           Moves
//  req_i    in   dlt_req_if.sink   one command per transfer
//  rsp_o    out  dlt_rsp_if.source one result per transfer
//
// From accept to result, close and set offset pass decode and the link read,
// lookup adds the entry read, open passes the slot scan, the entry scan and
// the open write, and close all goes through one link RAM read and one clear
// step per slot. The open search runs on the scanner, eight flags per cycle.
// req_i.ready is high only while the sequencer is idle; a result waits in the
// output register, so the next command may be taken while it stalls.
// Reset clears all slot valid and entry busy flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module two_level_descriptor_table_top import dlt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlt_req_if.sink   req_i,
  dlt_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_SLOT,
    ST_SCAN_ENT,
    ST_OPEN_WR,
    ST_LINK,
    ST_ENT_RD,
    ST_CA_RD,
    ST_CA_CLR,
    ST_RESP
  } state_e;

  state_e                    state_q;
  logic [2:0]                op_q;
  logic                      user_ok_q;
  logic                      desc_ok_q;
  logic [SLOT_W-1:0]         base_q;
  logic [DESC_W-1:0]         slot_f_q;
  logic [ENTRY_W-1:0]        ent_q;
  logic [CHUNK_W-1:0]        chunk_q;
  logic [15:0]               inode_q;
  logic [7:0]                flags_q;
  logic [31:0]               offset_q;
  rsp_t                      rsp_q;
  rsp_t                      rsp_data_q;
  logic                      rsp_valid_q;
  logic [SLOT_TOTAL-1:0]     slot_valid_q;
  logic [SYSTEM_ENTRIES-1:0] entry_busy_q;

  logic [SLOT_W-1:0]     slot_addr;
  logic                  slot_ok;
  logic [SCAN_LANES-1:0] slot_free;
  logic [SCAN_LANES-1:0] ent_free;
  logic [SCAN_LANES-1:0] scan_free;
  scan_res_t             scan_res;
  logic [SCAN_W-1:0]     found_idx;
  logic                  last_slot_chunk;
  logic                  last_ent_chunk;
  logic                  req_fire;
  rsp_t                  rsp_init;
  logic                  rsp_load;

  logic [ENTRY_W-1:0] link_rdata;
  logic [META_W-1:0]  meta_rdata;
  logic [31:0]        off_rdata;
  logic               off_we;
  logic [ENTRY_W-1:0] off_waddr;
  logic [31:0]        off_wdata;
  logic               open_wr;

  // Slot under work: the requested descriptor, the found slot or the walk index.
  assign slot_addr = base_q + SLOT_W'(slot_f_q);
  assign slot_ok   = user_ok_q && desc_ok_q && slot_valid_q[slot_addr];
  assign req_fire  = req_i.valid && req_i.ready;
  assign open_wr   = (state_q == ST_OPEN_WR);

  // Free flags of the current chunk for both searches.
  always_comb begin
    logic [SCAN_W-1:0] p;
    for (int k = 0; k < SCAN_LANES; k++) begin
      p            = {chunk_q, LANE_W'(k)};
      slot_free[k] = (32'(p) < SLOTS_PER_USER) && !slot_valid_q[base_q + SLOT_W'(p)];
      ent_free[k]  = (32'(p) < SYSTEM_ENTRIES) && !entry_busy_q[ENTRY_W'(p)];
    end
  end

  assign scan_free       = (state_q == ST_SCAN_ENT) ? ent_free : slot_free;
  assign found_idx       = {chunk_q, scan_res.lane};
  assign last_slot_chunk = (chunk_q == CHUNK_W'(SLOT_CHUNKS - 1));
  assign last_ent_chunk  = (chunk_q == CHUNK_W'(ENTRY_CHUNKS - 1));

  // Starting result of a command: failure, with the invalid inode for a lookup.
  always_comb begin
    rsp_init        = '0;
    rsp_init.status = 1'b1;
    if (op_q == OP_LOOKUP) begin
      rsp_init.inode_out = INODE_NONE;
    end
  end

  // The output register takes a new result when it is empty or being drained.
  assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_o.ready);

  dlt_scan u_scan (
    .free_i (scan_free),
    .res_o  (scan_res)
  );

  // Slot to entry links.
  dlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_TOTAL)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (open_wr),
    .waddr_i (slot_addr),
    .wdata_i (ent_q),
    .raddr_i (slot_addr),
    .rdata_o (link_rdata)
  );

  // Entry flags and inode, written only by open.
  dlt_ram #(
    .WIDTH (META_W),
    .DEPTH (SYSTEM_ENTRIES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (open_wr),
    .waddr_i (ent_q),
    .wdata_i ({flags_q, inode_q}),
    .raddr_i (link_rdata),
    .rdata_o (meta_rdata)
  );

  // Entry offsets: cleared by open, written by set offset.
  assign off_we    = open_wr || (state_q == ST_LINK && op_q == OP_SET_OFFSET);
  assign off_waddr = open_wr ? ent_q : link_rdata;
  assign off_wdata = open_wr ? 32'd0 : offset_q;

  dlt_ram #(
    .WIDTH (32),
    .DEPTH (SYSTEM_ENTRIES)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .raddr_i (link_rdata),
    .rdata_o (off_rdata)
  );

  // Sequencer, table flags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rsp_valid_q  <= 1'b0;
      slot_valid_q <= '0;
      entry_busy_q <= '0;
    end else begin
      // Output register: load a finished result or retire the one taken.
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
        rsp_data_q  <= rsp_q;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            op_q      <= req_i.opcode;
            user_ok_q <= ({1'b0, req_i.user} < 9'(USER_COUNT));
            desc_ok_q <= ({1'b0, req_i.descriptor} < 9'(SLOTS_PER_USER));
            base_q    <= SLOT_W'(32'(req_i.user) * SLOTS_PER_USER);
            slot_f_q  <= req_i.descriptor[DESC_W-1:0];
            inode_q   <= req_i.inode_in;
            flags_q   <= req_i.mode_flags;
            offset_q  <= req_i.new_offset;
            state_q   <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          rsp_q   <= rsp_init;
          chunk_q <= '0;
          case (op_q)
            OP_OPEN: begin
              state_q <= user_ok_q ? ST_SCAN_SLOT : ST_RESP;
            end
            OP_CLOSE, OP_SET_OFFSET: begin
              state_q <= slot_ok ? ST_LINK : ST_RESP;
            end
            OP_LOOKUP: begin
              state_q <= slot_ok ? ST_LINK : ST_RESP;
            end
            OP_CLOSE_ALL: begin
              slot_f_q <= '0;
              state_q  <= user_ok_q ? ST_CA_RD : ST_RESP;
            end
            default: begin
              state_q <= ST_RESP;
            end
          endcase
        end
        ST_SCAN_SLOT: begin
          if (scan_res.found) begin
            slot_f_q <= DESC_W'(found_idx);
            chunk_q  <= '0;
            state_q  <= ST_SCAN_ENT;
          end else if (last_slot_chunk) begin
            state_q <= ST_RESP;
          end else begin
            chunk_q <= chunk_q + CHUNK_W'(1);
          end
        end
        ST_SCAN_ENT: begin
          if (scan_res.found) begin
            ent_q   <= ENTRY_W'(found_idx);
            state_q <= ST_OPEN_WR;
          end else if (last_ent_chunk) begin
            state_q <= ST_RESP;
          end else begin
            chunk_q <= chunk_q + CHUNK_W'(1);
          end
        end
        ST_OPEN_WR: begin
          slot_valid_q[slot_addr] <= 1'b1;
          entry_busy_q[ent_q]     <= 1'b1;
          rsp_q.status            <= 1'b0;
          rsp_q.fd_out            <= 8'(slot_f_q);
          state_q                 <= ST_RESP;
        end
        ST_LINK: begin
          // Link read data is valid here.
          rsp_q.status <= 1'b0;
          case (op_q)
            OP_CLOSE: begin
              slot_valid_q[slot_addr]  <= 1'b0;
              entry_busy_q[link_rdata] <= 1'b0;
              state_q                  <= ST_RESP;
            end
            OP_LOOKUP: begin
              state_q <= ST_ENT_RD;
            end
            default: begin
              state_q <= ST_RESP;
            end
          endcase
        end
        ST_ENT_RD: begin
          rsp_q.inode_out  <= meta_rdata[15:0];
          rsp_q.flags_out  <= meta_rdata[23:16];
          rsp_q.offset_out <= off_rdata;
          rsp_q.is_open    <= 1'b1;
          state_q          <= ST_RESP;
        end
        ST_CA_RD: begin
          state_q <= ST_CA_CLR;
        end
        ST_CA_CLR: begin
          if (slot_valid_q[slot_addr]) begin
            slot_valid_q[slot_addr]  <= 1'b0;
            entry_busy_q[link_rdata] <= 1'b0;
          end
          if (slot_f_q == DESC_W'(SLOTS_PER_USER - 1)) begin
            rsp_q.status <= 1'b0;
            state_q      <= ST_RESP;
          end else begin
            slot_f_q <= slot_f_q + DESC_W'(1);
            state_q  <= ST_CA_RD;
          end
        end
        ST_RESP: begin
          if (rsp_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Port drive.
  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_data_q.status;
  assign rsp_o.fd_out     = rsp_data_q.fd_out;
  assign rsp_o.inode_out  = rsp_data_q.inode_out;
  assign rsp_o.offset_out = rsp_data_q.offset_out;
  assign rsp_o.flags_out  = rsp_data_q.flags_out;
  assign rsp_o.is_open    = rsp_data_q.is_open;

  // Every linked slot holds exactly one busy entry.
  a_link_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_valid_q) == $countones(entry_busy_q))
    else $error("slot and entry occupancy disagree");

  // The sequencer takes one command at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("command accepted while busy");

  // An open only links a free slot to a free entry.
  a_open_targets_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OPEN_WR |-> !entry_busy_q[ent_q] && !slot_valid_q[slot_addr])
    else $error("open targets an occupied slot or entry");

  // An open descriptor is always reported with success.
  a_open_is_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_data_q.is_open |-> !rsp_data_q.status)
    else $error("open descriptor reported with failure");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor table testbench
// Sends commands to the two-level descriptor table over the request channel
// and checks every result on the response channel, field by field, against
// a model of the slot and entry tables kept here or a directed row's own
// result. A short table of directed commands comes first, then random rounds
// that fill, churn and drain the tables while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import dlt_pkg::*;

  // Run shape.
  localparam int unsigned RANDOM_ITEMS    = 1300;
  localparam int unsigned ROUND_LEN       = 50;
  localparam int unsigned MAX_GAP         = 6;
  localparam int unsigned BURST_FIRST     = 500;
  localparam int unsigned BURST_LAST      = 700;
  localparam int unsigned HOLD_AT         = 900;
  localparam int unsigned RSP_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 60;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned FIELD_MAX       = 255;

  // Opcodes the block does not define.
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  user;
    logic [7:0]  desc;
    logic [15:0] inode;
    logic [7:0]  flags;
    logic [31:0] offset;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    rsp_t want;
  } row_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_e;

  // Results that are plain to see.
  localparam rsp_t RSP_OK         = '{1'b0, 8'd0, 16'h0, 32'h0, 8'h0, 1'b0};
  localparam rsp_t RSP_FAIL       = '{1'b1, 8'd0, 16'h0, 32'h0, 8'h0, 1'b0};
  localparam rsp_t RSP_BAD_LOOKUP = '{1'b1, 8'd0, INODE_NONE, 32'h0, 8'h0, 1'b0};

  // Directed commands; rows with typed set carry their own expected result.
  localparam int unsigned NUM_DIR = 26;
  localparam row_t DIR_TAB [NUM_DIR] = '{
    '{'{OP_LOOKUP,     8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_BAD_LOOKUP},
    '{'{OP_OPEN,       8'd255, 8'd0,   16'hFFFF, 8'hFF, 32'h0}, 1'b1, RSP_FAIL},
    '{'{OP_OPEN,       8'd8,   8'd0,   16'h0001, 8'h01, 32'h0}, 1'b1, RSP_FAIL},
    '{'{OP_OPEN,       8'd0,   8'd0,   16'hFFFF, 8'hFF, 32'h0}, 1'b1, RSP_OK},
    '{'{OP_OPEN,       8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1,
      '{1'b0, 8'd1, 16'h0, 32'h0, 8'h0, 1'b0}},
    '{'{OP_LOOKUP,     8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1,
      '{1'b0, 8'd0, 16'hFFFF, 32'h0, 8'hFF, 1'b1}},
    '{'{OP_SET_OFFSET, 8'd0,   8'd0,   16'h0,    8'h0,  32'hFFFF_FFFF}, 1'b1, RSP_OK},
    '{'{OP_LOOKUP,     8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1,
      '{1'b0, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1}},
    '{'{OP_SET_OFFSET, 8'd0,   8'd1,   16'h0,    8'h0,  32'h0}, 1'b0, RSP_OK},
    '{'{OP_LOOKUP,     8'd0,   8'd1,   16'h0,    8'h0,  32'h0}, 1'b0, RSP_OK},
    '{'{OP_LOOKUP,     8'd7,   8'd15,  16'h0,    8'h0,  32'h0}, 1'b1, RSP_BAD_LOOKUP},
    '{'{OP_LOOKUP,     8'd0,   8'd255, 16'h0,    8'h0,  32'h0}, 1'b1, RSP_BAD_LOOKUP},
    '{'{OP_LOOKUP,     8'd255, 8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_BAD_LOOKUP},
    '{'{OP_SET_OFFSET, 8'd0,   8'd16,  16'h0,    8'h0,  32'h1}, 1'b1, RSP_FAIL},
    '{'{OP_CLOSE,      8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_OK},
    '{'{OP_CLOSE,      8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_FAIL},
    '{'{OP_CLOSE,      8'd8,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_FAIL},
    '{'{OP_OPEN,       8'd0,   8'd0,   16'h1234, 8'h5A, 32'h0}, 1'b0, RSP_OK},
    '{'{OP_OPEN,       8'd7,   8'd0,   16'hA5A5, 8'h81, 32'h0}, 1'b0, RSP_OK},
    '{'{OP_LOOKUP,     8'd7,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b0, RSP_OK},
    '{'{OP_BAD_FIRST,  8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_FAIL},
    '{'{OP_BAD_LAST,   8'd255, 8'd255, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1, RSP_FAIL},
    '{'{OP_CLOSE_ALL,  8'd255, 8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_FAIL},
    '{'{OP_CLOSE_ALL,  8'd3,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_OK},
    '{'{OP_CLOSE_ALL,  8'd0,   8'd0,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_OK},
    '{'{OP_LOOKUP,     8'd0,   8'd1,   16'h0,    8'h0,  32'h0}, 1'b1, RSP_BAD_LOOKUP}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  dlt_req_if req_ch ();
  dlt_rsp_if rsp_ch ();

  two_level_descriptor_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Model of the tables; all zero is the state after reset.
  bit                     slot_used    [SLOT_TOTAL];
  bit [ENTRY_W-1:0]       slot_entry   [SLOT_TOTAL];
  bit                     entry_busy   [SYSTEM_ENTRIES];
  bit [7:0]               entry_flags  [SYSTEM_ENTRIES];
  bit [15:0]              entry_inode  [SYSTEM_ENTRIES];
  bit [31:0]              entry_offset [SYSTEM_ENTRIES];

  rsp_t        awaited_results [$];
  int unsigned n_sent, n_checked, n_mismatch, cycle_count;
  int unsigned n_open_ok, n_slot_full, n_entry_full, n_lookup_hit;
  logic        no_idle  = 1'b0;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Unlinks one slot and frees its entry; the count can only be one.
  function automatic void drop_link(input int s);
    bit [ENTRY_W-1:0] e;
    e = slot_entry[s];
    slot_used[s]    = 1'b0;
    slot_entry[s]   = '0;
    entry_busy[e]   = 1'b0;
    entry_flags[e]  = '0;
    entry_inode[e]  = '0;
    entry_offset[e] = '0;
  endfunction

  // Applies one command to the model tables and returns its result.
  function automatic rsp_t apply_table_cmd(input cmd_t c);
    rsp_t r;
    int   base, f, e, s;
    r    = RSP_FAIL;
    base = int'(c.user) * SLOTS_PER_USER;
    s    = -1;
    if (c.user < USER_COUNT && c.desc < SLOTS_PER_USER && slot_used[base + c.desc]) begin
      s = base + c.desc;
    end
    case (c.op)
      OP_OPEN: begin
        if (c.user < USER_COUNT) begin
          f = 0;
          while (f < SLOTS_PER_USER && slot_used[base + f]) f++;
          e = 0;
          while (e < SYSTEM_ENTRIES && entry_busy[e]) e++;
          if (f == SLOTS_PER_USER) begin
            n_slot_full++;
          end else if (e == SYSTEM_ENTRIES) begin
            n_entry_full++;
          end else begin
            entry_busy[e]      = 1'b1;
            entry_flags[e]     = c.flags;
            entry_inode[e]     = c.inode;
            entry_offset[e]    = '0;
            slot_used[base + f]  = 1'b1;
            slot_entry[base + f] = ENTRY_W'(e);
            r        = RSP_OK;
            r.fd_out = 8'(f);
            n_open_ok++;
          end
        end
      end
      OP_CLOSE: begin
        if (s >= 0) begin
          drop_link(s);
          r = RSP_OK;
        end
      end
      OP_LOOKUP: begin
        if (s >= 0) begin
          r            = RSP_OK;
          r.inode_out  = entry_inode[slot_entry[s]];
          r.offset_out = entry_offset[slot_entry[s]];
          r.flags_out  = entry_flags[slot_entry[s]];
          r.is_open    = 1'b1;
          n_lookup_hit++;
        end else begin
          r = RSP_BAD_LOOKUP;
        end
      end
      OP_SET_OFFSET: begin
        if (s >= 0) begin
          entry_offset[slot_entry[s]] = c.offset;
          r = RSP_OK;
        end
      end
      OP_CLOSE_ALL: begin
        if (c.user < USER_COUNT) begin
          for (f = 0; f < SLOTS_PER_USER; f++) begin
            if (slot_used[base + f]) drop_link(base + f);
          end
          r = RSP_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one command after a random gap and queues its expected result
  // once the transfer has taken place.
  task automatic issue_cmd(input cmd_t c, input logic typed, input rsp_t want);
    int   gap;
    rsp_t model;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= c.op;
    req_ch.user       <= c.user;
    req_ch.descriptor <= c.desc;
    req_ch.inode_in   <= c.inode;
    req_ch.mode_flags <= c.flags;
    req_ch.new_offset <= c.offset;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    model = apply_table_cmd(c);
    awaited_results.push_back(typed ? want : model);
    n_sent++;
  endtask

  task automatic flag_field(input string field, input logic [31:0] exp,
                            input logic [31:0] act);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
    n_mismatch++;
  endtask

  // Command side: reset, directed table, then random rounds.
  initial begin : command_side
    cmd_t cmd;
    mix_e mix;
    int   n, dice, focus, base, f;
    int   open_fds [$];
    rst_ni            <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= '0;
    req_ch.user       <= '0;
    req_ch.descriptor <= '0;
    req_ch.inode_in   <= '0;
    req_ch.mode_flags <= '0;
    req_ch.new_offset <= '0;
    mix   = MIX_BALANCED;
    focus = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands.
    for (n = 0; n < NUM_DIR; n++) begin
      issue_cmd(DIR_TAB[n].cmd, DIR_TAB[n].typed, DIR_TAB[n].want);
    end

    // Random rounds: each round fills, churns or drains the tables.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % ROUND_LEN == 0) begin
        dice  = $urandom_range(0, 9);
        mix   = (dice < 4) ? MIX_FILL : (dice < 8) ? MIX_BALANCED : MIX_DRAIN;
        focus = $urandom_range(0, USER_COUNT - 1);
      end
      no_idle = (n >= BURST_FIRST && n < BURST_LAST);

      // Pick the operation for this round's mix.
      dice = $urandom_range(0, 99);
      case (mix)
        MIX_FILL: begin
          if (dice < 75)      cmd.op = OP_OPEN;
          else if (dice < 90) cmd.op = OP_LOOKUP;
          else                cmd.op = OP_SET_OFFSET;
        end
        MIX_BALANCED: begin
          if (dice < 30)      cmd.op = OP_OPEN;
          else if (dice < 45) cmd.op = OP_CLOSE;
          else if (dice < 70) cmd.op = OP_LOOKUP;
          else if (dice < 92) cmd.op = OP_SET_OFFSET;
          else if (dice < 95) cmd.op = OP_CLOSE_ALL;
          else                cmd.op = $urandom_range(OP_BAD_FIRST, OP_BAD_LAST);
        end
        default: begin
          if (dice < 50)      cmd.op = OP_CLOSE;
          else if (dice < 56) cmd.op = OP_CLOSE_ALL;
          else if (dice < 80) cmd.op = OP_LOOKUP;
          else if (dice < 92) cmd.op = OP_SET_OFFSET;
          else                cmd.op = OP_OPEN;
        end
      endcase

      // Mostly valid users; a fill round mostly keeps to one user.
      if (mix == MIX_FILL && $urandom_range(0, 4) != 0) begin
        cmd.user = focus;
      end else if ($urandom_range(0, 9) != 0) begin
        cmd.user = $urandom_range(0, USER_COUNT - 1);
      end else begin
        cmd.user = $urandom_range(USER_COUNT, FIELD_MAX);
      end

      // Mostly a descriptor that is open, else any slot or out of range.
      open_fds.delete();
      if (cmd.user < USER_COUNT) begin
        base = int'(cmd.user) * SLOTS_PER_USER;
        for (f = 0; f < SLOTS_PER_USER; f++) begin
          if (slot_used[base + f]) open_fds.push_back(f);
        end
      end
      if (open_fds.size() > 0 && $urandom_range(0, 3) != 0) begin
        cmd.desc = open_fds[$urandom_range(0, open_fds.size() - 1)];
      end else if ($urandom_range(0, 6) != 0) begin
        cmd.desc = $urandom_range(0, SLOTS_PER_USER - 1);
      end else begin
        cmd.desc = $urandom_range(SLOTS_PER_USER, FIELD_MAX);
      end

      cmd.inode  = $urandom;
      cmd.flags  = $urandom;
      cmd.offset = $urandom;
      issue_cmd(cmd, 1'b0, RSP_OK);
    end
    no_idle = 1'b0;
    req_ch.valid <= 1'b0;

    // Wait for every result, then a little longer for strays.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d commands sent, %0d results checked, %0d mismatches",
             n_sent, n_checked, n_mismatch);
    $display("summary: %0d opens granted, %0d refused on full slots, %0d on full entries,",
             n_open_ok, n_slot_full, n_entry_full);
    $display("summary: %0d lookup hits", n_lookup_hit);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off that backs up the block.
  initial begin : response_side
    int stall;
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && n_sent >= NUM_DIR + HOLD_AT) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
    end
  end

  // Compares each result transfer with the oldest expected result.
  always @(posedge clk_i) begin : result_check
    rsp_t got, want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.status, rsp_ch.fd_out, rsp_ch.inode_out, rsp_ch.offset_out,
             rsp_ch.flags_out, rsp_ch.is_open};
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with no command waiting, expected none, actual %h",
                 $time, got);
        n_mismatch++;
      end else begin
        want = awaited_results.pop_front();
        n_checked++;
        if (got.status !== want.status) begin
          flag_field("status", want.status, got.status);
        end
        if (got.fd_out !== want.fd_out) begin
          flag_field("fd_out", want.fd_out, got.fd_out);
        end
        if (got.inode_out !== want.inode_out) begin
          flag_field("inode_out", want.inode_out, got.inode_out);
        end
        if (got.offset_out !== want.offset_out) begin
          flag_field("offset_out", want.offset_out, got.offset_out);
        end
        if (got.flags_out !== want.flags_out) begin
          flag_field("flags_out", want.flags_out, got.flags_out);
        end
        if (got.is_open !== want.is_open) begin
          flag_field("is_open", want.is_open, got.is_open);
        end
      end
    end
  end

  // Ends a hung run.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, awaited_results.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/dlt_pkg.sv
sv/dlt_req_if.sv
sv/dlt_rsp_if.sv
sv/dlt_ram.sv
sv/dlt_scan.sv
sv/two_level_descriptor_table_top.sv
tb/tb_top.sv
